@@ hw/rtl/hsl_to_rgb_converter_assert.svh @@
// ----------------------------------------------------------------------------
// hsl to rgb converter assertion macros
// same-cycle and next-cycle implication checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define HSL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hsl_to_rgb_converter: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define HSL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter: next-cycle check failed");

`else

`define HSL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HSL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/hsl_pkg.sv @@
// ----------------------------------------------------------------------------
// hsl_pkg
// shared types and constants of the hsl to rgb converter
// ----------------------------------------------------------------------------
package hsl_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 9;
	localparam int FULL_SCALE   = (1 << CHANNEL_BITS) - 1;

	// chroma numerator (1 - |2l - 1|) * s, up to full scale squared
	localparam int CN_BITS   = 2 * CHANNEL_BITS;
	// per-channel coefficient magnitude, 0..60
	localparam int COEF_BITS = 6;
	localparam int COEF_MAX  = 60;
	localparam int PROD_BITS = CN_BITS + COEF_BITS;

	// channel offset = floor(cn * coef / (120 * full scale))
	localparam int DIV_N    = 120 * FULL_SCALE;
	localparam int REM_BITS = $clog2(2 * DIV_N);

	// reciprocal estimate, low by at most one
	localparam int RECIP_SHIFT = PROD_BITS;
	localparam longint unsigned RECIP_MUL = (64'd1 << RECIP_SHIFT) / DIV_N;
	localparam int QE_BITS = RECIP_SHIFT + CHANNEL_BITS;

	localparam int PIPE_DEPTH = 7;

	typedef struct packed {
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] lightness;
	} hsl_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_t;

	// signed coefficient of chroma in one channel, over 120
	typedef struct packed {
		logic                 neg;
		logic [COEF_BITS-1:0] mag;
	} coef_t;

	typedef struct packed {
		coef_t red;
		coef_t green;
		coef_t blue;
	} rgb_coef_t;

	localparam coef_t COEF_CHROMA = '{neg: 1'b0, mag: COEF_BITS'(COEF_MAX)};
	localparam coef_t COEF_ZERO   = '{neg: 1'b1, mag: COEF_BITS'(COEF_MAX)};

endpackage

@@ hw/rtl/hsl_prep.sv @@
// ----------------------------------------------------------------------------
// hsl_prep
// stages 1 and 2: hue sector decode, chroma product and channel coefficients
// ----------------------------------------------------------------------------
module hsl_prep (
	input  logic                                clk,
	input  logic [hsl_pkg::PIPE_DEPTH:1]        stage_en,
	input  hsl_pkg::hsl_t                       hsl,
	output logic [hsl_pkg::CN_BITS-1:0]         cn_s2,
	output logic [hsl_pkg::CHANNEL_BITS-1:0]    light_s2,
	output hsl_pkg::rgb_coef_t                  coef_s2
);
	import hsl_pkg::*;

	localparam int SECTOR_DEG = 60;
	localparam int SECTORS    = 6;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	logic [2:0]              sector;
	logic [HUE_BITS-1:0]     base;
	logic [COEF_BITS-1:0]    t_deg;
	logic [COEF_BITS-1:0]    k_deg;
	logic [COEF_BITS:0]      k2;
	coef_t                   coef_x;
	rgb_coef_t               coef;
	logic                    fallback;
	logic [CHANNEL_BITS:0]   light2;
	logic [CHANNEL_BITS-1:0] amp;

	logic [CHANNEL_BITS-1:0] amp_s1;
	logic [CHANNEL_BITS-1:0] sat_s1;
	logic [CHANNEL_BITS-1:0] light_s1;
	rgb_coef_t               coef_s1;

	// sector by threshold compares
	always_comb begin
		sector = SEC_0;
		base   = '0;
		for (int i = 1; i < SECTORS; i++) begin
			if (hsl.hue >= HUE_BITS'(i * SECTOR_DEG)) begin
				sector = 3'(i);
				base   = HUE_BITS'(i * SECTOR_DEG);
			end
		end
		fallback = (hsl.hue >= HUE_BITS'(SECTORS * SECTOR_DEG));
		t_deg    = COEF_BITS'(hsl.hue - base);
		// k = 60 - |(hue mod 120) - 60|
		k_deg    = sector[0] ? COEF_BITS'(COEF_MAX) - t_deg : t_deg;
		k2       = {k_deg, 1'b0};
		if (k2 >= (COEF_BITS + 1)'(COEF_MAX)) begin
			coef_x.neg = 1'b0;
			coef_x.mag = COEF_BITS'(k2 - (COEF_BITS + 1)'(COEF_MAX));
		end else begin
			coef_x.neg = 1'b1;
			coef_x.mag = COEF_BITS'((COEF_BITS + 1)'(COEF_MAX) - k2);
		end
	end

	always_comb begin
		coef = '{red: COEF_ZERO, green: COEF_ZERO, blue: COEF_ZERO};
		if (!fallback) begin
			unique case (sector)
				SEC_0: begin
					coef.red   = COEF_CHROMA;
					coef.green = coef_x;
				end
				SEC_1: begin
					coef.red   = coef_x;
					coef.green = COEF_CHROMA;
				end
				SEC_2: begin
					coef.green = COEF_CHROMA;
					coef.blue  = coef_x;
				end
				SEC_3: begin
					coef.green = coef_x;
					coef.blue  = COEF_CHROMA;
				end
				SEC_4: begin
					coef.red   = coef_x;
					coef.blue  = COEF_CHROMA;
				end
				SEC_5: begin
					coef.red   = COEF_CHROMA;
					coef.blue  = coef_x;
				end
				default: begin
					coef = '{red: COEF_ZERO, green: COEF_ZERO, blue: COEF_ZERO};
				end
			endcase
		end
	end

	// 1 - |2l - 1| in full-scale units
	always_comb begin
		light2 = {hsl.lightness, 1'b0};
		if (light2 >= (CHANNEL_BITS + 1)'(FULL_SCALE)) begin
			amp = CHANNEL_BITS'((CHANNEL_BITS + 1)'(2 * FULL_SCALE) - light2);
		end else begin
			amp = CHANNEL_BITS'(light2);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			amp_s1   <= amp;
			sat_s1   <= hsl.saturation;
			light_s1 <= hsl.lightness;
			coef_s1  <= coef;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			cn_s2    <= CN_BITS'(amp_s1) * CN_BITS'(sat_s1);
			light_s2 <= light_s1;
			coef_s2  <= coef_s1;
		end
	end

endmodule

@@ hw/rtl/hsl_chan.sv @@
// ----------------------------------------------------------------------------
// hsl_chan
// stages 3 to 6 of one channel: floor(cn * coef / (120 * full scale))
// ----------------------------------------------------------------------------
module hsl_chan (
	input  logic                             clk,
	input  logic [hsl_pkg::PIPE_DEPTH:1]     stage_en,
	input  logic [hsl_pkg::CN_BITS-1:0]      cn_s2,
	input  hsl_pkg::coef_t                   coef_s2,
	output logic [hsl_pkg::CHANNEL_BITS-1:0] mag_s6,
	output logic                             neg_s6
);
	import hsl_pkg::*;

	logic [PROD_BITS-1:0]    prod_s3;
	logic                    neg_s3;
	logic [QE_BITS-1:0]      qe_s4;
	logic [PROD_BITS-1:0]    prod_s4;
	logic                    neg_s4;
	logic [CHANNEL_BITS-1:0] est_s5;
	logic [REM_BITS-1:0]     rem_s5;
	logic                    neg_s5;

	logic [CHANNEL_BITS-1:0] est;
	logic [PROD_BITS-1:0]    back;
	logic [CHANNEL_BITS-1:0] quo;
	logic                    rem_zero;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			prod_s3 <= PROD_BITS'(cn_s2) * PROD_BITS'(coef_s2.mag);
			neg_s3  <= coef_s2.neg;
		end
	end

	// reciprocal multiply
	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			qe_s4   <= QE_BITS'(prod_s3) * QE_BITS'(RECIP_MUL);
			prod_s4 <= prod_s3;
			neg_s4  <= neg_s3;
		end
	end

	// quotient estimate and its remainder, remainder below twice the divisor
	always_comb begin
		est  = qe_s4[RECIP_SHIFT +: CHANNEL_BITS];
		back = PROD_BITS'(est) * PROD_BITS'(DIV_N);
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			est_s5 <= est;
			rem_s5 <= REM_BITS'(prod_s4 - back);
			neg_s5 <= neg_s4;
		end
	end

	// single correction step, then round away from zero for negative floor
	always_comb begin
		if (rem_s5 >= REM_BITS'(DIV_N)) begin
			quo      = est_s5 + 1'b1;
			rem_zero = (rem_s5 == REM_BITS'(DIV_N));
		end else begin
			quo      = est_s5;
			rem_zero = (rem_s5 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			mag_s6 <= quo + CHANNEL_BITS'(neg_s5 & ~rem_zero);
			neg_s6 <= neg_s5;
		end
	end

endmodule

@@ hw/rtl/hsl_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// streaming hsl to rgb pixel converter, seven-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   hsl channel: one request per pixel (hue in degrees, saturation and
//   lightness with full scale meaning 1.0), taken when hsl_valid and
//   hsl_ready are both high
//   rgb channel: one result per request, in order, offered on rgb_valid
//   and held until rgb_ready
//   throughput is one pixel every cycle while the receiver keeps rgb_ready high
//   the depth comes from the arithmetic chain, each step registered: sector
//   decode, chroma product, chroma times coefficient, reciprocal multiply,
//   back multiply for the remainder, correction, then add to lightness and clamp
//   reset clears every stage valid bit; payload registers are not reset
//   when the receiver stalls, ready ripples back only through occupied
//   stages, so bubbles close up and requests are still taken until the
//   pipeline is full; nothing is dropped or repeated
//   hue of 360 or more gives the grey level on all three channels
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsl_valid,
	output logic          hsl_ready,
	input  hsl_pkg::hsl_t hsl,
	output logic          rgb_valid,
	input  logic          rgb_ready,
	output hsl_pkg::rgb_t rgb
);
	import hsl_pkg::*;

	// per-stage valid bits and load enables
	logic [PIPE_DEPTH:1] vld_q;
	logic [PIPE_DEPTH:1] stage_en;

	// front end outputs
	logic [CN_BITS-1:0]      cn_s2;
	logic [CHANNEL_BITS-1:0] light_s2;
	rgb_coef_t               coef_s2;

	// lightness rides along with the channel arithmetic
	logic [CHANNEL_BITS-1:0] light_s3;
	logic [CHANNEL_BITS-1:0] light_s4;
	logic [CHANNEL_BITS-1:0] light_s5;
	logic [CHANNEL_BITS-1:0] light_s6;

	// signed channel offsets from the per-channel units
	logic [CHANNEL_BITS-1:0] red_mag_s6;
	logic [CHANNEL_BITS-1:0] green_mag_s6;
	logic [CHANNEL_BITS-1:0] blue_mag_s6;
	logic                    red_neg_s6;
	logic                    green_neg_s6;
	logic                    blue_neg_s6;

	rgb_t rgb_s7;

	// lightness plus or minus offset, clamped to 0..full scale
	function automatic logic [CHANNEL_BITS-1:0] clamp_chan(
		input logic [CHANNEL_BITS-1:0] light,
		input logic [CHANNEL_BITS-1:0] mag,
		input logic                    neg
	);
		logic [CHANNEL_BITS:0] sum;
		logic [CHANNEL_BITS-1:0] res;
		sum = {1'b0, light} + {1'b0, mag};
		if (neg) begin
			res = (mag > light) ? '0 : light - mag;
		end else if (sum > (CHANNEL_BITS + 1)'(FULL_SCALE)) begin
			res = CHANNEL_BITS'(FULL_SCALE);
		end else begin
			res = CHANNEL_BITS'(sum);
		end
		return res;
	endfunction

	// a stage loads when it is empty or the stage after it moves
	always_comb begin
		stage_en[PIPE_DEPTH] = ~vld_q[PIPE_DEPTH] | rgb_ready;
		for (int i = PIPE_DEPTH - 1; i >= 1; i--) begin
			stage_en[i] = ~vld_q[i] | stage_en[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				vld_q[1] <= hsl_valid;
			end
			for (int i = 2; i <= PIPE_DEPTH; i++) begin
				if (stage_en[i]) begin
					vld_q[i] <= vld_q[i - 1];
				end
			end
		end
	end

	assign hsl_ready = stage_en[1];

	// stages 1 and 2
	hsl_prep u_prep (
		.clk      (clk),
		.stage_en (stage_en),
		.hsl      (hsl),
		.cn_s2    (cn_s2),
		.light_s2 (light_s2),
		.coef_s2  (coef_s2)
	);

	// stages 3 to 6, one unit per channel
	hsl_chan u_chan_red (
		.clk      (clk),
		.stage_en (stage_en),
		.cn_s2    (cn_s2),
		.coef_s2  (coef_s2.red),
		.mag_s6   (red_mag_s6),
		.neg_s6   (red_neg_s6)
	);

	hsl_chan u_chan_green (
		.clk      (clk),
		.stage_en (stage_en),
		.cn_s2    (cn_s2),
		.coef_s2  (coef_s2.green),
		.mag_s6   (green_mag_s6),
		.neg_s6   (green_neg_s6)
	);

	hsl_chan u_chan_blue (
		.clk      (clk),
		.stage_en (stage_en),
		.cn_s2    (cn_s2),
		.coef_s2  (coef_s2.blue),
		.mag_s6   (blue_mag_s6),
		.neg_s6   (blue_neg_s6)
	);

	// lightness delay line matching the channel units
	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			light_s3 <= light_s2;
		end
		if (stage_en[4]) begin
			light_s4 <= light_s3;
		end
		if (stage_en[5]) begin
			light_s5 <= light_s4;
		end
		if (stage_en[6]) begin
			light_s6 <= light_s5;
		end
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			rgb_s7.red   <= clamp_chan(light_s6, red_mag_s6, red_neg_s6);
			rgb_s7.green <= clamp_chan(light_s6, green_mag_s6, green_neg_s6);
			rgb_s7.blue  <= clamp_chan(light_s6, blue_mag_s6, blue_neg_s6);
		end
	end

	assign rgb_valid = vld_q[PIPE_DEPTH];
	assign rgb       = rgb_s7;

	// an empty or draining output stage never blocks new requests
	`HSL_ASSERT_IMP(a_ready_when_drain, clk, arst_n, (!rgb_valid || rgb_ready), hsl_ready)
	// a stalled stage keeps its item and its lightness
	`HSL_ASSERT_NXT(a_hold_on_stall, clk, arst_n, (vld_q[6] && !stage_en[7]), (vld_q[6] && $stable(light_s6)))
	// a result only appears from an occupied stage before it
	`HSL_ASSERT_IMP(a_result_source, clk, arst_n, $rose(rgb_valid), $past(vld_q[6]))

endmodule

@@ verif/tb_hsl_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_converter
// self-checking bench: drives hsl requests with random gaps, stalls the rgb
// side at random, and checks each rgb result against an exact-rational
// predictor; a directed table of boundary pixels runs before random pixels
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter;

	import hsl_pkg::*;

	localparam int RANDOM_PIXELS = 650;
	localparam int MAX_WAIT      = 11;
	// cycles with no request or result taken before the run is abandoned
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = PIPE_DEPTH + 10;

	// one directed pixel; typed_in marks rows whose result is written here
	typedef struct packed {
		logic                    typed_in;
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] lightness;
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} pixel_row_t;

	localparam int DIRECTED_ROWS = 24;

	localparam pixel_row_t DIRECTED_PIXELS [DIRECTED_ROWS] = '{
		// black, white and greys: readable at a glance
		'{1'b1, 9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{1'b1, 9'd511, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
		'{1'b1, 9'd200, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{1'b1, 9'd400, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{1'b1, 9'd360, 8'd0,   8'd100, 8'd100, 8'd100, 8'd100},
		'{1'b1, 9'd359, 8'd0,   8'd37,  8'd37,  8'd37,  8'd37},
		// both edges of every hue sector at full saturation, mid lightness
		'{1'b0, 9'd0,   8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd59,  8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd60,  8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd119, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd120, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd179, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd180, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd239, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd240, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd299, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd300, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd359, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0},
		// fallback branch with nonzero chroma
		'{1'b0, 9'd360, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd511, 8'd255, 8'd200, 8'd0,   8'd0,   8'd0},
		// mixed values inside sectors
		'{1'b0, 9'd30,  8'd128, 8'd64,  8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd90,  8'd255, 8'd200, 8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd256, 8'd170, 8'd85,  8'd0,   8'd0,   8'd0},
		'{1'b0, 9'd330, 8'd1,   8'd254, 8'd0,   8'd0,   8'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic hsl_valid;
	logic hsl_ready;
	hsl_t hsl;
	logic rgb_valid;
	logic rgb_ready;
	rgb_t rgb;

	// colors still owed by the block, oldest first
	rgb_t pending_rgb_q [$];
	int   mismatch_count = 0;
	int   quiet_cycles   = 0;

	always #5 clk = ~clk;

	hsl_to_rgb_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsl_valid (hsl_valid),
		.hsl_ready (hsl_ready),
		.hsl       (hsl),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	// ------------------------------------------------------------------
	// color predictor: every quantity is a numerator over 120 * D * D,
	// so the only rounding is the final truncation of each channel
	// ------------------------------------------------------------------
	function automatic logic [CHANNEL_BITS-1:0] channel_level(longint num, longint den);
		longint lvl;
		if (num <= 0)
			return '0;
		lvl = (num * FULL_SCALE) / den;
		// cannot trigger with legal inputs, clamp to full scale
		if (lvl > FULL_SCALE)
			lvl = FULL_SCALE;
		return CHANNEL_BITS'(lvl);
	endfunction

	function automatic rgb_t predict_rgb(hsl_t px);
		longint full;
		longint hue_deg;
		longint sat;
		longint lit;
		longint light_dev;
		longint chroma_num;
		longint common_den;
		longint chroma_part;
		longint ramp;
		longint x_part;
		longint grey_part;
		longint r_part;
		longint g_part;
		longint b_part;
		rgb_t   color;
		full        = FULL_SCALE;
		hue_deg     = px.hue;
		sat         = px.saturation;
		lit         = px.lightness;
		// |2L - 1| scaled by D
		light_dev   = 2 * lit - full;
		if (light_dev < 0)
			light_dev = -light_dev;
		chroma_num  = (full - light_dev) * sat;
		common_den  = 120 * full * full;
		chroma_part = chroma_num * 120;
		// 1 - |(h/60 mod 2) - 1| times 60, a triangle over each 120 degrees
		ramp        = (hue_deg % 120) - 60;
		if (ramp < 0)
			ramp = -ramp;
		ramp        = 60 - ramp;
		x_part      = chroma_num * ramp * 2;
		grey_part   = lit * 120 * full - chroma_num * 60;
		r_part      = 0;
		g_part      = 0;
		b_part      = 0;
		// hue of 360 and up leaves all three at the grey level
		if (hue_deg < 360) begin
			case (hue_deg / 60)
				0: begin
					r_part = chroma_part;
					g_part = x_part;
				end
				1: begin
					r_part = x_part;
					g_part = chroma_part;
				end
				2: begin
					g_part = chroma_part;
					b_part = x_part;
				end
				3: begin
					g_part = x_part;
					b_part = chroma_part;
				end
				4: begin
					r_part = x_part;
					b_part = chroma_part;
				end
				default: begin
					r_part = chroma_part;
					b_part = x_part;
				end
			endcase
		end
		color.red   = channel_level(r_part + grey_part, common_den);
		color.green = channel_level(g_part + grey_part, common_den);
		color.blue  = channel_level(b_part + grey_part, common_den);
		return color;
	endfunction

	// level draw that leans on the extremes and the mid-scale pair
	function automatic logic [CHANNEL_BITS-1:0] draw_level();
		logic [CHANNEL_BITS-1:0] lvl;
		case ($urandom_range(0, 9))
			0: lvl = '0;
			1: lvl = CHANNEL_BITS'(FULL_SCALE);
			2: lvl = CHANNEL_BITS'(FULL_SCALE / 2 + $urandom_range(0, 1));
			default: lvl = CHANNEL_BITS'($urandom_range(0, FULL_SCALE));
		endcase
		return lvl;
	endfunction

	// ------------------------------------------------------------------
	// request driver: called at a rising edge, returns at the edge where
	// the request is taken; valid stays high across back-to-back requests
	// ------------------------------------------------------------------
	task automatic send_pixel(input hsl_t px, input bit typed_in, input rgb_t typed_rgb,
		input int gap);
		rgb_t want;
		want = typed_in ? typed_rgb : predict_rgb(px);
		if (gap > 0) begin
			hsl_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsl_valid <= 1'b1;
		hsl       <= px;
		do
			@(posedge clk);
		while (!hsl_ready);
		pending_rgb_q.push_back(want);
	endtask

	// gap before request n: every 64 requests open with a run of no gaps
	function automatic int sender_gap(int n);
		return (n % 64 < 16) ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		hsl_t px;
		rgb_t typed_rgb;
		int   sent;
		arst_n    = 1'b0;
		hsl_valid = 1'b0;
		hsl       = '0;
		sent      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			px.hue          = DIRECTED_PIXELS[i].hue;
			px.saturation   = DIRECTED_PIXELS[i].saturation;
			px.lightness    = DIRECTED_PIXELS[i].lightness;
			typed_rgb.red   = DIRECTED_PIXELS[i].red;
			typed_rgb.green = DIRECTED_PIXELS[i].green;
			typed_rgb.blue  = DIRECTED_PIXELS[i].blue;
			send_pixel(px, DIRECTED_PIXELS[i].typed_in, typed_rgb, sender_gap(sent));
			sent++;
		end

		// random pixels; about a quarter land on the fallback hues
		typed_rgb = '0;
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if ($urandom_range(0, 3) == 0)
				px.hue = HUE_BITS'($urandom_range(360, (1 << HUE_BITS) - 1));
			else
				px.hue = HUE_BITS'($urandom_range(0, 359));
			px.saturation = draw_level();
			px.lightness  = draw_level();
			send_pixel(px, 1'b0, typed_rgb, sender_gap(sent));
			sent++;
		end
		hsl_valid <= 1'b0;

		// let the pipeline drain, then watch for stray results
		while (pending_rgb_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("hsl_to_rgb_converter: match");
		else
			$display("hsl_to_rgb_converter: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side: random stall before each result, runs of no stall
	// ------------------------------------------------------------------
	initial begin
		int stall;
		int taken;
		rgb_ready = 1'b0;
		taken     = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (taken % 48 < 12) ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				rgb_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rgb_valid === 1'b1 && rgb_ready === 1'b1));
			taken++;
		end
	end

	// compare every taken result with the oldest owed color
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (pending_rgb_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: rgb result with no request owed: expected none, got r=%0d g=%0d b=%0d",
					$time, rgb.red, rgb.green, rgb.blue);
			end else begin
				want = pending_rgb_q.pop_front();
				if (rgb.red !== want.red || rgb.green !== want.green
					|| rgb.blue !== want.blue) begin
					mismatch_count++;
					$display("%0t: rgb differs: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
						$time, want.red, want.green, want.blue,
						rgb.red, rgb.green, rgb.blue);
				end
			end
		end
	end

	// watchdog: too long with nothing taken on either side
	always @(posedge clk) begin
		if (!arst_n || (hsl_valid && hsl_ready) || (rgb_valid && rgb_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("hsl_to_rgb_converter: mismatch");
				$finish;
			end
		end
	end

endmodule
